// ===== rtl/core/gbr_pkg.sv =====
// Shared types, constants and helpers for the Gaussian blur row pass.
`default_nettype none
package gbr_pkg;

  localparam int MAX_RADIUS = 5;
  localparam int NUM_TAPS   = 2 * MAX_RADIUS + 1;
  localparam int TAP_W      = $clog2(NUM_TAPS);
  localparam int RAD_W      = 3;
  localparam int SEEN_W     = 3;
  localparam int CNT_W      = 4;
  localparam int WEIGHT_W   = 16;
  localparam int NUM_WEIGHTS = MAX_RADIUS + 1;
  localparam int CH_W       = 8;
  localparam int PROD_W     = WEIGHT_W + CH_W;
  localparam int GROUP_SIZE = 4;
  localparam int NUM_GROUPS = (NUM_TAPS + GROUP_SIZE - 1) / GROUP_SIZE;
  localparam int PART_W     = CH_W + $clog2(GROUP_SIZE);
  localparam int SUM_W      = CH_W + $clog2(NUM_TAPS + 1);
  localparam int ADDR_W     = 5;
  localparam int DATA_W     = 32;

  localparam logic [SEEN_W-1:0] SEEN_MAX = 3'd7;
  localparam logic [CH_W-1:0]   CH_MAX   = 8'd255;

  localparam logic [RAD_W-1:0]    RADIUS_RST = 3'd1;
  localparam logic [WEIGHT_W-1:0] W_CENTER_RST = 16'd34213;
  localparam logic [WEIGHT_W-1:0] W_DIST1_RST  = 16'd15664;

  typedef enum logic [2:0] {
    REG_RADIUS   = 3'd0,
    REG_W_CENTER = 3'd1,
    REG_W_DIST1  = 3'd2,
    REG_W_DIST2  = 3'd3,
    REG_W_DIST3  = 3'd4,
    REG_W_DIST4  = 3'd5,
    REG_W_DIST5  = 3'd6
  } cfg_reg_e;

  typedef enum logic {
    ST_ROW   = 1'b0,
    ST_FLUSH = 1'b1
  } ctrl_state_e;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
  } pixel_t;

  typedef logic [NUM_WEIGHTS-1:0][WEIGHT_W-1:0] weights_t;
  typedef logic [2:0][CH_W-1:0] terms_t;
  typedef terms_t [NUM_TAPS-1:0] tap_terms_t;

  // window update control from sequencer to cell chain
  typedef struct packed {
    logic load;        // window advances this cycle
    logic fill;        // first pixel of row: every cell takes it
    logic from_input;  // cell 0 shifts in the input pixel (else repeats itself)
  } win_ctl_t;

  // tag riding along with a window snapshot down the pipe
  typedef struct packed {
    logic valid;
    logic done;
  } stage_tag_t;

  typedef struct packed {
    logic [CH_W-1:0] red;
    logic [CH_W-1:0] green;
    logic [CH_W-1:0] blue;
    logic            row_done;
  } result_t;

  function automatic logic [RAD_W-1:0] eff_radius(input logic [RAD_W-1:0] r);
    eff_radius = (r > RAD_W'(MAX_RADIUS)) ? RAD_W'(MAX_RADIUS) : r;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/gbr_pix_in_if.sv =====
// Input pixel stream interface.
`default_nettype none
interface gbr_pix_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  logic       last_in_row;

  modport source (output valid, output red_in, output green_in, output blue_in,
                  output last_in_row, input ready);
  modport sink   (input valid, input red_in, input green_in, input blue_in,
                  input last_in_row, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gbr_pix_out_if.sv =====
// Output (blurred) pixel stream interface.
`default_nettype none
interface gbr_pix_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       row_done;

  modport source (output valid, output red_out, output green_out, output blue_out,
                  output row_done, input ready);
  modport sink   (input valid, input red_out, input green_out, input blue_out,
                  input row_done, output ready);
endinterface
`default_nettype wire

// ===== rtl/core/gbr_cfg_regs.sv =====
// APB configuration registers: radius and kernel weights.
`default_nettype none
module gbr_cfg_regs (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                psel,
  input  logic                                penable,
  input  logic                                pwrite,
  input  logic [gbr_pkg::ADDR_W-1:0]          paddr,
  input  logic [gbr_pkg::DATA_W-1:0]          pwdata,
  output logic [gbr_pkg::DATA_W-1:0]          prdata,
  output logic                                pready,
  output logic [gbr_pkg::RAD_W-1:0]           radius_o,
  output gbr_pkg::weights_t                   weights_o
);
  import gbr_pkg::*;

  logic [RAD_W-1:0] radius_q;
  weights_t         weights_q;
  logic             wr_en;
  cfg_reg_e         reg_sel;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_sel = cfg_reg_e'(paddr[ADDR_W-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q  <= RADIUS_RST;
      weights_q <= {{((NUM_WEIGHTS - 2) * WEIGHT_W){1'b0}}, W_DIST1_RST, W_CENTER_RST};
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_RADIUS:   radius_q     <= pwdata[RAD_W-1:0];
        REG_W_CENTER: weights_q[0] <= pwdata[WEIGHT_W-1:0];
        REG_W_DIST1:  weights_q[1] <= pwdata[WEIGHT_W-1:0];
        REG_W_DIST2:  weights_q[2] <= pwdata[WEIGHT_W-1:0];
        REG_W_DIST3:  weights_q[3] <= pwdata[WEIGHT_W-1:0];
        REG_W_DIST4:  weights_q[4] <= pwdata[WEIGHT_W-1:0];
        REG_W_DIST5:  weights_q[5] <= pwdata[WEIGHT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_sel)
      REG_RADIUS:   prdata = DATA_W'(radius_q);
      REG_W_CENTER: prdata = DATA_W'(weights_q[0]);
      REG_W_DIST1:  prdata = DATA_W'(weights_q[1]);
      REG_W_DIST2:  prdata = DATA_W'(weights_q[2]);
      REG_W_DIST3:  prdata = DATA_W'(weights_q[3]);
      REG_W_DIST4:  prdata = DATA_W'(weights_q[4]);
      REG_W_DIST5:  prdata = DATA_W'(weights_q[5]);
      default:      prdata = '0;
    endcase
  end

  assign radius_o  = eff_radius(radius_q);
  assign weights_o = weights_q;

endmodule
`default_nettype wire

// ===== rtl/core/gbr_tap_cell.sv =====
// One window cell: holds a pixel, passes it on, and forms its weighted tap terms.
`default_nettype none
module gbr_tap_cell (
  input  logic                       clk_i,
  input  logic [gbr_pkg::TAP_W-1:0]  tap_idx_i,
  input  logic [gbr_pkg::RAD_W-1:0]  radius_i,
  input  gbr_pkg::weights_t          weights_i,
  input  logic                       load_i,
  input  logic                       fill_i,
  input  gbr_pkg::pixel_t            fill_px_i,
  input  gbr_pkg::pixel_t            shift_px_i,
  input  logic                       prod_en_i,
  output gbr_pkg::pixel_t            px_o,
  output gbr_pkg::terms_t            terms_o
);
  import gbr_pkg::*;

  pixel_t              px_q;
  terms_t              terms_q;
  terms_t              terms_d;
  logic [TAP_W-1:0]    r_ext;
  logic [TAP_W-1:0]    tap_dist;
  logic                in_use;
  logic [WEIGHT_W-1:0] w;
  logic [PROD_W-1:0]   prod_r;
  logic [PROD_W-1:0]   prod_g;
  logic [PROD_W-1:0]   prod_b;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      px_q <= fill_i ? fill_px_i : shift_px_i;
    end
  end

  // distance from the window center, taps beyond 2R drop out
  always_comb begin
    r_ext    = TAP_W'(radius_i);
    tap_dist = (tap_idx_i >= r_ext) ? (tap_idx_i - r_ext) : (r_ext - tap_idx_i);
    in_use   = (tap_idx_i <= {r_ext[TAP_W-2:0], 1'b0});
    w        = '0;
    if (in_use && (tap_dist < TAP_W'(NUM_WEIGHTS))) begin
      w = weights_i[tap_dist[$clog2(NUM_WEIGHTS)-1:0]];
    end
    prod_r = PROD_W'(w) * PROD_W'(px_q.red);
    prod_g = PROD_W'(w) * PROD_W'(px_q.green);
    prod_b = PROD_W'(w) * PROD_W'(px_q.blue);
    terms_d[0] = prod_r[PROD_W-1:WEIGHT_W];
    terms_d[1] = prod_g[PROD_W-1:WEIGHT_W];
    terms_d[2] = prod_b[PROD_W-1:WEIGHT_W];
  end

  always_ff @(posedge clk_i) begin
    if (prod_en_i) begin
      terms_q <= terms_d;
    end
  end

  assign px_o    = px_q;
  assign terms_o = terms_q;

endmodule
`default_nettype wire

// ===== rtl/core/gbr_ctrl.sv =====
// Row sequencer: pixel count, right-edge flush and emit decisions.
`default_nettype none
module gbr_ctrl (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      in_valid_i,
  input  logic                      in_last_i,
  input  logic [gbr_pkg::RAD_W-1:0] radius_i,
  input  logic                      rdy1_i,
  output logic                      in_ready_o,
  output gbr_pkg::win_ctl_t         win_ctl_o,
  output gbr_pkg::stage_tag_t       tag_o,
  output logic                      flushing_o
);
  import gbr_pkg::*;

  ctrl_state_e       state_q, state_d;
  logic [SEEN_W-1:0] seen_q, seen_d;
  logic [RAD_W-1:0]  step_q, step_d;
  stage_tag_t        tag_q, tag_d;
  logic              adv0;
  logic              take;
  logic              flush_end;
  logic [SEEN_W-1:0] seen_inc;
  logic [CNT_W-1:0]  thresh;
  logic [CNT_W-1:0]  flush_cnt;

  assign adv0      = !tag_q.valid || rdy1_i;
  assign take      = (state_q == ST_ROW) && in_valid_i && adv0;
  assign flush_end = (state_q == ST_FLUSH) && adv0 && (step_q == radius_i);
  assign seen_inc  = (seen_q == SEEN_MAX) ? seen_q : seen_q + 1'b1;
  assign thresh    = CNT_W'(radius_i) + 1'b1;
  assign flush_cnt = CNT_W'(seen_q) + CNT_W'(step_q);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ROW: begin
        if (take && in_last_i && (radius_i != '0)) state_d = ST_FLUSH;
      end
      ST_FLUSH: begin
        if (flush_end) state_d = ST_ROW;
      end
      default: state_d = ST_ROW;
    endcase
  end

  always_comb begin
    in_ready_o = 1'b0;
    win_ctl_o  = '0;
    tag_d      = tag_q;
    seen_d     = seen_q;
    step_d     = step_q;
    unique case (state_q)
      ST_ROW: begin
        in_ready_o           = adv0;
        win_ctl_o.load       = take;
        win_ctl_o.fill       = take && (seen_q == '0);
        win_ctl_o.from_input = 1'b1;
        if (take) begin
          tag_d.valid = (CNT_W'(seen_inc) >= thresh);
          tag_d.done  = in_last_i && (radius_i == '0);
          seen_d      = (in_last_i && (radius_i == '0)) ? '0 : seen_inc;
          step_d      = RAD_W'(1);
        end else if (adv0) begin
          tag_d = '0;
        end
      end
      ST_FLUSH: begin
        win_ctl_o.load = adv0;
        if (adv0) begin
          tag_d.valid = (flush_cnt >= thresh);
          tag_d.done  = (step_q == radius_i);
          step_d      = step_q + 1'b1;
          if (flush_end) seen_d = '0;
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_ROW;
      seen_q  <= '0;
      step_q  <= '0;
      tag_q   <= '0;
    end else begin
      state_q <= state_d;
      seen_q  <= seen_d;
      step_q  <= step_d;
      tag_q   <= tag_d;
    end
  end

  assign tag_o      = tag_q;
  assign flushing_o = (state_q == ST_FLUSH);

endmodule
`default_nettype wire

// ===== rtl/core/gbr_sum.sv =====
// Two-stage tap adder with saturation and the output register.
`default_nettype none
module gbr_sum (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  gbr_pkg::tap_terms_t terms_i,
  input  gbr_pkg::stage_tag_t tag_i,
  output logic                ready_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output gbr_pkg::result_t    res_o
);
  import gbr_pkg::*;

  stage_tag_t                             tag2_q;
  logic [NUM_GROUPS-1:0][2:0][PART_W-1:0] part_q, part_d;
  logic                                   v3_q;
  result_t                                res_q, res_d;
  logic                                   rdy3;
  logic [2:0][SUM_W-1:0]                  total;

  assign rdy3    = !v3_q || out_ready_i;
  assign ready_o = !tag2_q.valid || rdy3;

  always_comb begin
    part_d = '0;
    for (int t = 0; t < NUM_TAPS; t++) begin
      for (int c = 0; c < 3; c++) begin
        part_d[t / GROUP_SIZE][c] = part_d[t / GROUP_SIZE][c] + PART_W'(terms_i[t][c]);
      end
    end
  end

  always_comb begin
    total = '0;
    for (int c = 0; c < 3; c++) begin
      for (int g = 0; g < NUM_GROUPS; g++) begin
        total[c] = total[c] + SUM_W'(part_q[g][c]);
      end
    end
    res_d.red      = (total[0] > SUM_W'(CH_MAX)) ? CH_MAX : total[0][CH_W-1:0];
    res_d.green    = (total[1] > SUM_W'(CH_MAX)) ? CH_MAX : total[1][CH_W-1:0];
    res_d.blue     = (total[2] > SUM_W'(CH_MAX)) ? CH_MAX : total[2][CH_W-1:0];
    res_d.row_done = tag2_q.done;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag2_q <= '0;
      v3_q   <= 1'b0;
    end else begin
      if (ready_o) tag2_q <= tag_i;
      if (rdy3)    v3_q   <= tag2_q.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o) part_q <= part_d;
    if (rdy3)    res_q  <= res_d;
  end

  assign out_valid_o = v3_q;
  assign res_o       = res_q;

endmodule
`default_nettype wire

// ===== rtl/core/gaussian_blur_row_pass_unit.sv =====
// Top level of the horizontal Gaussian blur pass over an RGB pixel stream.
//
//  channel   dir  handshake     payload
//  pix_i     in   valid/ready   red_in, green_in, blue_in, last_in_row
//  res_o     out  valid/ready   red_out, green_out, blue_out, row_done
//  apb       in   psel/penable  radius, weight_center, weight_dist_1..5
//
// One pixel transaction per cycle inside a row, unless res_o stalls back to the
// input. After the last pixel of a row the window shifts R more times (R =
// radius, at most 5) with input held off. A result passes through the tap
// products, partial sums and output reg after the window step that forms it.
// Reset clears the sequencer and all stage valid flags; stalls on res_o back
// up stage by stage, so input keeps flowing while bubbles remain in the pipe.
`default_nettype none
module gaussian_blur_row_pass_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  gbr_pix_in_if.sink                    pix_i,
  gbr_pix_out_if.source                 res_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [gbr_pkg::ADDR_W-1:0]    paddr,
  input  logic [gbr_pkg::DATA_W-1:0]    pwdata,
  output logic [gbr_pkg::DATA_W-1:0]    prdata,
  output logic                          pready
);
  import gbr_pkg::*;

  logic [RAD_W-1:0] radius;
  weights_t         weights;
  win_ctl_t         win_ctl;
  stage_tag_t       tag0;
  stage_tag_t       tag1_q;
  logic             rdy1;
  logic             rdy2;
  logic             flushing;
  logic             in_ready;
  pixel_t           in_px;
  pixel_t           head_px;
  pixel_t [NUM_TAPS-1:0] win_px;
  tap_terms_t       terms;
  result_t          res;
  logic             out_valid;

  gbr_cfg_regs u_regs (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .psel      (psel),
    .penable   (penable),
    .pwrite    (pwrite),
    .paddr     (paddr),
    .pwdata    (pwdata),
    .prdata    (prdata),
    .pready    (pready),
    .radius_o  (radius),
    .weights_o (weights)
  );

  // Sequencer decides window moves and which window snapshots are results.
  gbr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (pix_i.valid),
    .in_last_i  (pix_i.last_in_row),
    .radius_i   (radius),
    .rdy1_i     (rdy1),
    .in_ready_o (in_ready),
    .win_ctl_o  (win_ctl),
    .tag_o      (tag0),
    .flushing_o (flushing)
  );

  assign pix_i.ready = in_ready;
  assign in_px.red   = pix_i.red_in;
  assign in_px.green = pix_i.green_in;
  assign in_px.blue  = pix_i.blue_in;

  // During the right-edge flush cell 0 repeats the row's last pixel.
  assign head_px = win_ctl.from_input ? in_px : win_px[0];

  // Stage 1 (tap products in the cells) loads whenever it is empty or drains.
  assign rdy1 = !tag1_q.valid || rdy2;

  for (genvar t = 0; t < NUM_TAPS; t++) begin : g_cell
    pixel_t shift_px;
    if (t == 0) begin : g_head
      assign shift_px = head_px;
    end else begin : g_body
      assign shift_px = win_px[t-1];
    end

    gbr_tap_cell u_cell (
      .clk_i      (clk_i),
      .tap_idx_i  (TAP_W'(t)),
      .radius_i   (radius),
      .weights_i  (weights),
      .load_i     (win_ctl.load),
      .fill_i     (win_ctl.fill),
      .fill_px_i  (in_px),
      .shift_px_i (shift_px),
      .prod_en_i  (rdy1),
      .px_o       (win_px[t]),
      .terms_o    (terms[t])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tag1_q <= '0;
    end else if (rdy1) begin
      tag1_q <= tag0;
    end
  end

  gbr_sum u_sum (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .terms_i     (terms),
    .tag_i       (tag1_q),
    .ready_o     (rdy2),
    .out_valid_o (out_valid),
    .out_ready_i (res_o.ready),
    .res_o       (res)
  );

  assign res_o.valid     = out_valid;
  assign res_o.red_out   = res.red;
  assign res_o.green_out = res.green;
  assign res_o.blue_out  = res.blue;
  assign res_o.row_done  = res.row_done;

`ifndef NO_ASSERTIONS
  // no pixel may be taken while the right edge is still being replicated
  a_flush_holds_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flushing |-> !pix_i.ready)
    else $error("input accepted during row flush");

  // a pending window snapshot must not be overwritten before stage 1 takes it
  a_window_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag0.valid && !rdy1) |=> $stable(win_px))
    else $error("window moved under a pending result");

  // end-of-row marker only rides on a real result
  a_done_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (tag0.done || tag1_q.done) |-> ((tag0.valid || !tag0.done) &&
                                    (tag1_q.valid || !tag1_q.done)))
    else $error("row_done tag without a result");
`endif

endmodule
`default_nettype wire

// ===== verif/gaussian_blur_row_pass_unit_tb.sv =====
// Self-checking testbench for the horizontal Gaussian blur row pass unit.
module gaussian_blur_row_pass_unit_tb;
  import gbr_pkg::*;

  // Idle settling after the last result, covers window step plus 3 pipe stages
  localparam int DRAIN_CYCLES  = 12;
  localparam int STALL_CYCLES  = 300;
  localparam int IDLE_PCT      = 14;
  localparam int NUM_PHASES    = 8;
  localparam int PHASE_ITEMS   = 36;
  localparam int REPORT_LIMIT  = 10;
  // index 7 has no register behind it, a write there must change nothing
  localparam logic [2:0] REG_UNMAPPED = 3'd7;

  typedef enum logic {
    STEP_PIXEL = 1'b0,
    STEP_WRITE = 1'b1
  } step_kind_e;

  // One row of the directed table: either a pixel transaction or a register write.
  // known marks a single-pixel row whose result is typed in by hand.
  typedef struct packed {
    step_kind_e  kind;
    logic [2:0]  reg_idx;
    logic [31:0] value;
    pixel_t      px;
    logic        last;
    logic        known;
    pixel_t      known_px;
  } dir_step_t;

  logic clk_i;
  logic rst_ni;
  logic psel;
  logic penable;
  logic pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic pready;

  gbr_pix_in_if  pix_if ();
  gbr_pix_out_if res_if ();

  gaussian_blur_row_pass_unit uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .pix_i   (pix_if),
    .res_o   (res_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // ---------------------------------------------------------------------------
  // Mirror of the block: window of pixels (newest at 0), row counter, registers
  // ---------------------------------------------------------------------------
  pixel_t        win_q [NUM_TAPS];
  logic [2:0]    seen_cnt;
  logic [2:0]    radius_reg;
  logic [15:0]   weight_reg [NUM_WEIGHTS];

  // blurred pixels still owed by the block, oldest first
  result_t       blurred_q [$];

  int  pixels_sent;
  int  results_seen;
  int  regs_written;
  int  mismatches;
  bit  no_idle;
  bit  stall_request;
  int  stall_left;

  // ---------------------------------------------------------------------------
  // Directed table builders
  // ---------------------------------------------------------------------------
  function automatic dir_step_t pixel_step(int r, int g, int b, bit last);
    dir_step_t s;
    s = '0;
    s.kind = STEP_PIXEL;
    s.px = '{red: 8'(r), green: 8'(g), blue: 8'(b)};
    s.last = last;
    return s;
  endfunction

  // single-pixel row with a hand-computed result
  function automatic dir_step_t known_step(int r, int g, int b, int er, int eg, int eb);
    dir_step_t s;
    s = pixel_step(r, g, b, 1'b1);
    s.known = 1'b1;
    s.known_px = '{red: 8'(er), green: 8'(eg), blue: 8'(eb)};
    return s;
  endfunction

  function automatic dir_step_t write_step(logic [2:0] idx, int val);
    dir_step_t s;
    s = '0;
    s.kind = STEP_WRITE;
    s.reg_idx = idx;
    s.value = 32'(val);
    return s;
  endfunction

  localparam int DIR_LEN = 36;
  dir_step_t dir_tab [DIR_LEN] = '{
    // reset settings: R = 1, weights 34213 / 15664
    known_step(0, 0, 0, 0, 0, 0),
    known_step(255, 255, 255, 253, 253, 253),   // 133 + 60 + 60
    pixel_step(255, 0, 255, 1'b0),
    pixel_step(0, 255, 0, 1'b0),
    pixel_step(170, 85, 51, 1'b0),
    pixel_step(12, 200, 7, 1'b1),
    // radius raised in the middle of a row
    pixel_step(100, 50, 25, 1'b0),
    write_step(REG_RADIUS, 3),
    pixel_step(200, 10, 90, 1'b0),
    pixel_step(5, 5, 5, 1'b1),
    // every weight at full scale
    write_step(REG_W_CENTER, 65535),
    write_step(REG_W_DIST1, 65535),
    write_step(REG_W_DIST2, 65535),
    write_step(REG_W_DIST3, 65535),
    write_step(REG_W_DIST4, 65535),
    write_step(REG_W_DIST5, 65535),
    write_step(REG_RADIUS, 1),
    known_step(255, 255, 255, 255, 255, 255),   // 3 * 254 saturates
    // radius 7 behaves as 5; row shorter than R+1 flushes on its last pixel
    write_step(REG_RADIUS, 7),
    write_step(REG_UNMAPPED, 1),
    pixel_step(9, 8, 7, 1'b0),
    pixel_step(240, 128, 1, 1'b0),
    pixel_step(33, 66, 99, 1'b1),
    // single tap
    write_step(REG_RADIUS, 0),
    pixel_step(1, 2, 3, 1'b0),
    pixel_step(254, 253, 252, 1'b1),
    // radius 6 also clamps to 5, row long enough to bring the seen counter to its limit
    write_step(REG_RADIUS, 6),
    pixel_step(0, 0, 0, 1'b0),
    pixel_step(255, 255, 255, 1'b0),
    pixel_step(1, 254, 128, 1'b0),
    pixel_step(77, 3, 200, 1'b0),
    pixel_step(255, 0, 0, 1'b0),
    pixel_step(0, 0, 255, 1'b0),
    pixel_step(90, 180, 45, 1'b1),
    write_step(REG_W_CENTER, 0),
    pixel_step(128, 128, 128, 1'b1)
  };

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------
  function automatic result_t blur_at(int r);
    int acc_r = 0;
    int acc_g = 0;
    int acc_b = 0;
    int d;
    int w;
    result_t res;
    for (int t = 0; t <= 2 * r; t++) begin
      d = (t >= r) ? t - r : r - t;
      w = int'(weight_reg[d]);
      // each tap term is truncated on its own before summing
      acc_r += (w * int'(win_q[t].red)) >> 16;
      acc_g += (w * int'(win_q[t].green)) >> 16;
      acc_b += (w * int'(win_q[t].blue)) >> 16;
    end
    res.red      = (acc_r > 255) ? CH_MAX : 8'(acc_r);
    res.green    = (acc_g > 255) ? CH_MAX : 8'(acc_g);
    res.blue     = (acc_b > 255) ? CH_MAX : 8'(acc_b);
    res.row_done = 1'b0;
    return res;
  endfunction

  task automatic shift_window(input pixel_t px);
    for (int t = NUM_TAPS - 1; t > 0; t--) win_q[t] = win_q[t-1];
    win_q[0] = px;
  endtask

  // Advance the mirror by one accepted pixel; n_res = results it causes.
  task automatic predict_pixel(input pixel_t px, input bit last, output int n_res);
    int r;
    int seen_now;
    result_t tail;
    r = (int'(radius_reg) > MAX_RADIUS) ? MAX_RADIUS : int'(radius_reg);
    n_res = 0;
    // first pixel of a row fills the window: left edge replicated
    if (seen_cnt == '0) begin
      for (int t = 0; t < NUM_TAPS; t++) win_q[t] = px;
    end else begin
      shift_window(px);
    end
    if (seen_cnt < SEEN_MAX) seen_cnt = seen_cnt + 3'd1;
    seen_now = int'(seen_cnt);
    if (seen_now >= r + 1) begin
      blurred_q.push_back(blur_at(r));
      n_res++;
    end
    if (last) begin
      // right edge: last pixel repeated R times, everything pending drains
      for (int s = 1; s <= r; s++) begin
        shift_window(px);
        if (seen_now + s >= r + 1) begin
          blurred_q.push_back(blur_at(r));
          n_res++;
        end
      end
      if (n_res > 0) begin
        tail = blurred_q[$];
        tail.row_done = 1'b1;
        blurred_q[$] = tail;
      end
      seen_cnt = '0;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Clock and run limit
  // ---------------------------------------------------------------------------
  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    #5_000_000;
    $display("CHECKS FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Drivers
  // ---------------------------------------------------------------------------

  // Offer one pixel, wait for the transaction, then update the mirror.
  // Handshake is looked at on the falling edge, where everything has settled.
  task automatic send_pixel(input pixel_t px, input bit last, output int n_res);
    bit taken;
    while (!no_idle && $urandom_range(0, 99) < IDLE_PCT) begin
      pix_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_if.valid       <= 1'b1;
    pix_if.red_in      <= px.red;
    pix_if.green_in    <= px.green;
    pix_if.blue_in     <= px.blue;
    pix_if.last_in_row <= last;
    do begin
      @(negedge clk_i);
      taken = pix_if.ready;
      @(posedge clk_i);
    end while (!taken);
    pixels_sent++;
    predict_pixel(px, last, n_res);
  endtask

  // APB write: setup phase, access phase until pready, then psel low again before returning.
  task automatic cfg_write(input logic [2:0] idx, input logic [31:0] value);
    bit done;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk_i);
    penable <= 1'b1;
    do begin
      @(negedge clk_i);
      done = pready;
      @(posedge clk_i);
    end while (!done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    regs_written++;
    case (idx)
      REG_RADIUS:   radius_reg    = value[2:0];
      REG_W_CENTER: weight_reg[0] = value[15:0];
      REG_W_DIST1:  weight_reg[1] = value[15:0];
      REG_W_DIST2:  weight_reg[2] = value[15:0];
      REG_W_DIST3:  weight_reg[3] = value[15:0];
      REG_W_DIST4:  weight_reg[4] = value[15:0];
      REG_W_DIST5:  weight_reg[5] = value[15:0];
      default: ;  // unmapped: ignored
    endcase
    @(posedge clk_i);
  endtask

  // Stop offering, let every owed result out, then let the pipe settle.
  task automatic wait_drained();
    pix_if.valid <= 1'b0;
    while (blurred_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // ---------------------------------------------------------------------------
  // Result side: ready with random gaps, plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    res_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (stall_request) begin
        stall_left    = STALL_CYCLES;
        stall_request = 1'b0;
      end
      if (stall_left > 0) begin
        res_if.ready <= 1'b0;
        stall_left--;
      end else begin
        res_if.ready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  task automatic log_mismatch(input string what, input result_t want, input result_t got);
    mismatches++;
    if (mismatches <= REPORT_LIMIT)
      $display({"mismatch (%s) at %0t: expected r=%0d g=%0d b=%0d done=%0d, ",
                "got r=%0d g=%0d b=%0d done=%0d"},
               what, $realtime, want.red, want.green, want.blue, want.row_done,
               got.red, got.green, got.blue, got.row_done);
  endtask

  // Compare every result transaction with the oldest owed pixel
  initial begin
    result_t got;
    result_t want;
    forever begin
      @(negedge clk_i);
      if (rst_ni && res_if.valid && res_if.ready) begin
        got.red      = res_if.red_out;
        got.green    = res_if.green_out;
        got.blue     = res_if.blue_out;
        got.row_done = res_if.row_done;
        results_seen++;
        if (blurred_q.size() == 0) begin
          log_mismatch("nothing owed", '0, got);
        end else begin
          want = blurred_q.pop_front();
          if (got.red !== want.red || got.green !== want.green ||
              got.blue !== want.blue || got.row_done !== want.row_done)
            log_mismatch("field", want, got);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Main sequence
  // ---------------------------------------------------------------------------
  initial begin
    int        n_res;
    int        sent;
    int        row_len;
    pixel_t    px;
    result_t   e;
    logic [2:0]  rad;
    logic [15:0] w;

    pixels_sent   = 0;
    results_seen  = 0;
    regs_written  = 0;
    mismatches    = 0;
    no_idle       = 1'b0;
    stall_request = 1'b0;
    stall_left    = 0;

    // every input known from time zero
    rst_ni             <= 1'b0;
    pix_if.valid       <= 1'b0;
    pix_if.red_in      <= '0;
    pix_if.green_in    <= '0;
    pix_if.blue_in     <= '0;
    pix_if.last_in_row <= 1'b0;
    psel               <= 1'b0;
    penable            <= 1'b0;
    pwrite             <= 1'b0;
    paddr              <= '0;
    pwdata             <= '0;

    // mirror comes out of reset like the block
    for (int t = 0; t < NUM_TAPS; t++) win_q[t] = '0;
    seen_cnt   = '0;
    radius_reg = RADIUS_RST;
    for (int k = 0; k < NUM_WEIGHTS; k++) weight_reg[k] = '0;
    weight_reg[0] = W_CENTER_RST;
    weight_reg[1] = W_DIST1_RST;

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed table ---
    for (int i = 0; i < DIR_LEN; i++) begin
      if (dir_tab[i].kind == STEP_WRITE) begin
        wait_drained();
        cfg_write(dir_tab[i].reg_idx, dir_tab[i].value);
      end else begin
        send_pixel(dir_tab[i].px, dir_tab[i].last, n_res);
        // hand-typed rows replace the predicted pixel, row_done stays predicted
        if (dir_tab[i].known) begin
          for (int k = blurred_q.size() - n_res; k < blurred_q.size(); k++) begin
            e = blurred_q[k];
            e.red   = dir_tab[i].known_px.red;
            e.green = dir_tab[i].known_px.green;
            e.blue  = dir_tab[i].known_px.blue;
            blurred_q[k] = e;
          end
        end
      end
    end

    // --- random phases, one register setting each ---
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      wait_drained();
      case (ph)
        0: rad = 3'd5;
        1: rad = 3'd0;
        2: rad = 3'd2;
        3: rad = 3'd7;
        default: rad = 3'($urandom_range(0, 7));
      endcase
      cfg_write(REG_RADIUS, 32'(rad));
      for (int k = 0; k < NUM_WEIGHTS; k++) begin
        case (ph % 3)
          0: w = 16'($urandom_range(0, 16383));          // mostly unsaturated sums
          1: w = 16'($urandom);
          default: w = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        endcase
        if (ph == NUM_PHASES - 1) w = '0;               // all-zero kernel
        cfg_write(3'(int'(REG_W_CENTER) + k), 32'(w));
      end

      no_idle = (ph == 2);                              // back-to-back stretch
      if (ph == 4) stall_request = 1'b1;                // result side holds off
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        // mostly short rows, some longer than the seen counter saturates at
        row_len = ($urandom_range(0, 5) == 0) ? $urandom_range(11, 24) : $urandom_range(1, 10);
        // last row of the phase is cut to the phase budget
        if (row_len > PHASE_ITEMS - sent) row_len = PHASE_ITEMS - sent;
        for (int j = 0; j < row_len; j++) begin
          px = 24'($urandom);
          send_pixel(px, j == row_len - 1, n_res);
          sent++;
          // sender pauses after the phase's tenth pixel until all results are back
          if (ph == 5 && sent == 10) wait_drained();
        end
      end
      no_idle = 1'b0;
    end

    // --- end of run ---
    pix_if.valid <= 1'b0;
    for (int c = 0; c < 20000 && blurred_q.size() != 0; c++) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (blurred_q.size() != 0) begin
      $display("%0d blurred pixels never arrived", blurred_q.size());
      mismatches += blurred_q.size();
    end

    $display("Sent %0d pixels in directed and random rows over radius 0..7, %0d register writes",
             pixels_sent, regs_written);
    $display("Checked %0d blurred pixels, %0d mismatches", results_seen, mismatches);
    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
